@@ rtl/hsi2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsi2rgb_pkg
// Shared widths, hue constants and the elaboration-time functions that build the cosine ratio table.
// ----------------------------------------------------------------------------
package hsi2rgb_pkg;

  localparam int HUE_W      = 9;
  localparam int CHAN_W     = 8;
  localparam int SECTOR_W   = 2;
  localparam int OFFSET_W   = 7;

  localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd120;
  localparam logic [HUE_W-1:0] HUE_TWO_SECT = 9'd240;
  localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;

  localparam logic [SECTOR_W-1:0] SECT_RED   = 2'd0;
  localparam logic [SECTOR_W-1:0] SECT_GREEN = 2'd1;
  localparam logic [SECTOR_W-1:0] SECT_BLUE  = 2'd2;

  localparam int  TABLE_DEPTH = 120;
  localparam int  HALF_TURN   = 60;
  localparam longint COS_STEP = 64'sd1073578288;
  localparam longint SIN_STEP = 64'sd18739379;

  // Round a Q60 product back to Q30, halves away from zero.
  function automatic longint round_q30(longint v);
    longint half;
    half = 64'sd1 <<< 29;
    if (v >= 0) begin
      return (v + half) >>> 30;
    end
    return -((-v + half) >>> 30);
  endfunction

  // Cosine of k degrees in Q30, built by repeated one-degree rotation.
  function automatic longint cos_q30(int k);
    longint c;
    longint s;
    longint nc;
    longint ns;
    int     n;
    c = 64'sd1 <<< 30;
    s = 64'sd0;
    for (n = 0; n < k; n++) begin
      nc = round_q30(c * COS_STEP - s * SIN_STEP);
      ns = round_q30(s * COS_STEP + c * SIN_STEP);
      c  = nc;
      s  = ns;
    end
    return c;
  endfunction

  // Restoring long division on non-negative operands.
  function automatic longint long_div(longint n, longint d);
    longint q;
    longint r;
    int     b;
    q = 64'sd0;
    r = 64'sd0;
    for (b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Ratio cos(k)/cos(60-k) with frac_bits fraction bits, rounded.
  function automatic longint ratio_at(int k, int frac_bits);
    int     j;
    longint num;
    longint mag;
    longint den;
    longint q;
    j   = (k <= HALF_TURN) ? (HALF_TURN - k) : (k - HALF_TURN);
    num = cos_q30(k);
    mag = (num < 0) ? -num : num;
    den = cos_q30(j);
    if (den == 0) begin
      den = 64'sd1;
    end
    q = long_div((mag <<< frac_bits) + (den >>> 1), den);
    return (num < 0) ? -q : q;
  endfunction

endpackage

@@ rtl/hsi2rgb_in_if.sv @@
// ----------------------------------------------------------------------------
// hsi2rgb_in_if
// Pixel word channel: hue, saturation, intensity with valid/ready.
// ----------------------------------------------------------------------------
interface hsi2rgb_in_if import hsi2rgb_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] intensity;

  modport source (output valid, hue, saturation, intensity, input ready);
  modport sink   (input valid, hue, saturation, intensity, output ready);

endinterface

@@ rtl/hsi2rgb_out_if.sv @@
// ----------------------------------------------------------------------------
// hsi2rgb_out_if
// Color word channel: red, green, blue with valid/ready.
// ----------------------------------------------------------------------------
interface hsi2rgb_out_if import hsi2rgb_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);

endinterface

@@ rtl/hsi_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter
// HSI to RGB pixel conversion, eight-stage pipeline, one word per clock while not stalled.
// ----------------------------------------------------------------------------
// The block takes one pixel word (hue in whole degrees, saturation and
// intensity with 255 as full scale) in every clock cycle while the output is
// not stalled, and returns the matching red/green/blue word through eight
// register stages. Throughput is one word per cycle without a stall. Each stage
// has its own valid bit and load enable, so a stall on the output holds only
// the stages that are full, and empty stages upstream keep taking words.
// Hue values from 360 to 511 wrap to hue-360. The cosine ratio of each sector
// offset comes from a 120-entry constant table built at elaboration with
// RATIO_FRAC_BITS fraction bits. The major channel is i(1+s*R), the minor is
// i(1-s), the third takes what is left of 3i; major and third clamp to 0..255.
// ----------------------------------------------------------------------------
module hsi_to_rgb_converter import hsi2rgb_pkg::*; #(
  parameter int RATIO_FRAC_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsi2rgb_in_if.sink     pix_i,
  hsi2rgb_out_if.source  rgb_o
);

  // Ratio in [-1, 2], signed with room for the sign.
  localparam int RAT_W  = RATIO_FRAC_BITS + 3;
  // s * R, with s taken as a positive 9-bit signed value.
  localparam int SR_W   = RAT_W + CHAN_W + 1;
  // 255*2^F + s*R does not exceed 765*2^F.
  localparam int T_W    = RATIO_FRAC_BITS + 10;
  localparam int NUM_W  = T_W + CHAN_W;
  localparam int Y_W    = NUM_W - RATIO_FRAC_BITS;
  localparam int PY_W   = Y_W + 9;
  localparam int QY_W   = PY_W - 16;
  localparam int MAJ_W  = 10;
  localparam int MN_W   = 2 * CHAN_W;
  localparam int PM_W   = MN_W + 9;
  localparam int QM_W   = PM_W - 16;
  localparam int TH_W   = 12;

  localparam logic [T_W-1:0]   D_VAL  = T_W'(255) << RATIO_FRAC_BITS;
  localparam logic [NUM_W-1:0] HALF_D = NUM_W'(255) << (RATIO_FRAC_BITS - 1);

  // Cosine ratio table, constant, one entry per degree of sector offset.
  logic signed [RAT_W-1:0] ratio_rom [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
    assign ratio_rom[k] = RAT_W'(ratio_at(k, RATIO_FRAC_BITS));
  end

  // Stage valid bits and load enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  assign en8 = !vo_q || rgb_o.ready;
  assign en7 = !v7_q || en8;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pix_i.ready = en1;

  // Stage 1: wrap hue, pick sector, reduce to an offset.
  logic [SECTOR_W-1:0] sec1_d, sec1_q;
  logic [OFFSET_W-1:0] off1_d, off1_q;
  logic [CHAN_W-1:0]   sat1_q, int1_q;
  logic [HUE_W-1:0]    hw;
  logic [HUE_W-1:0]    hoff;

  always_comb begin
    hw = (pix_i.hue >= HUE_FULL) ? (pix_i.hue - HUE_FULL) : pix_i.hue;
    if (hw >= HUE_TWO_SECT) begin
      sec1_d = SECT_BLUE;
      hoff   = hw - HUE_TWO_SECT;
    end else if (hw >= SECTOR_DEG) begin
      sec1_d = SECT_GREEN;
      hoff   = hw - SECTOR_DEG;
    end else begin
      sec1_d = SECT_RED;
      hoff   = hw;
    end
    off1_d = hoff[OFFSET_W-1:0];
  end

  // Stage 2: table read, minor product.
  logic [SECTOR_W-1:0]     sec2_q;
  logic [CHAN_W-1:0]       sat2_q, int2_q;
  logic signed [RAT_W-1:0] rat2_q;
  logic [MN_W-1:0]         mn2_d, mn2_q;

  assign mn2_d = MN_W'(int1_q) * MN_W'(8'd255 - sat1_q) + MN_W'(127);

  // Stage 3: s * R, reciprocal product for the minor divide by 255.
  logic [SECTOR_W-1:0]    sec3_q;
  logic [CHAN_W-1:0]      int3_q;
  logic signed [SR_W-1:0] sr3_d, sr3_q;
  logic [PM_W-1:0]        pm3_d, pm3_q;
  logic [MN_W-1:0]        ym3_q;

  assign sr3_d = SR_W'($signed({1'b0, sat2_q}) * rat2_q);
  assign pm3_d = PM_W'({mn2_q, 8'b0}) + PM_W'(mn2_q);

  // Stage 4: offset s*R by 255*2^F, finish the minor quotient.
  logic [SECTOR_W-1:0]    sec4_q;
  logic [CHAN_W-1:0]      int4_q;
  logic [T_W-1:0]         t4_d, t4_q;
  logic [CHAN_W-1:0]      mnr4_d, mnr4_q;
  logic signed [SR_W-1:0] t_sum;
  logic [QM_W-1:0]        qm;
  logic [MN_W:0]          rm;

  always_comb begin
    t_sum  = $signed({2'b00, D_VAL}) + sr3_q;
    t4_d   = t_sum[T_W-1:0];
    qm     = pm3_q[PM_W-1:16];
    rm     = {1'b0, ym3_q} - (MN_W+1)'(({qm, 8'b0}) - (QM_W+8)'(qm));
    mnr4_d = (rm >= (MN_W+1)'(255)) ? CHAN_W'(qm + 1'b1) : CHAN_W'(qm);
  end

  // Stage 5: full major numerator i * (255*2^F + s*R).
  logic [SECTOR_W-1:0] sec5_q;
  logic [CHAN_W-1:0]   int5_q, mnr5_q;
  logic [NUM_W-1:0]    num5_d, num5_q;

  assign num5_d = NUM_W'(int4_q) * NUM_W'(t4_q);

  // Stage 6: round, drop the fraction, reciprocal product by 257.
  logic [SECTOR_W-1:0] sec6_q;
  logic [CHAN_W-1:0]   int6_q, mnr6_q;
  logic [NUM_W-1:0]    nsum;
  logic [Y_W-1:0]      y6_d, y6_q;
  logic [PY_W-1:0]     p6_d, p6_q;

  always_comb begin
    nsum = num5_q + HALF_D;
    y6_d = nsum[NUM_W-1:RATIO_FRAC_BITS];
    p6_d = PY_W'({y6_d, 8'b0}) + PY_W'(y6_d);
  end

  // Stage 7: correct the major quotient by one where needed.
  logic [SECTOR_W-1:0] sec7_q;
  logic [CHAN_W-1:0]   int7_q, mnr7_q;
  logic [MAJ_W-1:0]    maj7_d, maj7_q;
  logic [QY_W-1:0]     qy;
  logic [Y_W:0]        ry;

  always_comb begin
    qy     = p6_q[PY_W-1:16];
    ry     = {1'b0, y6_q} - (Y_W+1)'(({qy, 8'b0}) - (QY_W+8)'(qy));
    maj7_d = (ry >= (Y_W+1)'(255)) ? MAJ_W'(qy + 1'b1) : MAJ_W'(qy);
  end

  // Stage 8: third channel, saturate, route by sector.
  logic [CHAN_W-1:0]      red_d, green_d, blue_d;
  logic [CHAN_W-1:0]      red_q, green_q, blue_q;
  logic signed [TH_W-1:0] third;
  logic [CHAN_W-1:0]      maj_c, thr_c;

  always_comb begin
    third = $signed(TH_W'(3 * int7_q)) - $signed(TH_W'(mnr7_q))
            - $signed(TH_W'(maj7_q));
    maj_c = (maj7_q > MAJ_W'(255)) ? 8'd255 : maj7_q[CHAN_W-1:0];
    if (third < 0) begin
      thr_c = 8'd0;
    end else if (third > TH_W'(255)) begin
      thr_c = 8'd255;
    end else begin
      thr_c = third[CHAN_W-1:0];
    end
    case (sec7_q)
      SECT_RED: begin
        red_d = maj_c;  green_d = thr_c;  blue_d = mnr7_q;
      end
      SECT_GREEN: begin
        red_d = mnr7_q; green_d = maj_c;  blue_d = thr_c;
      end
      SECT_BLUE: begin
        red_d = thr_c;  green_d = mnr7_q; blue_d = maj_c;
      end
      default: begin
        red_d = thr_c;  green_d = mnr7_q; blue_d = maj_c;
      end
    endcase
  end

  // Valid bits: advance with each stage's enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
      if (en8) vo_q <= v7_q;
    end
  end

  // Payload registers: load on enable, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q <= sec1_d; off1_q <= off1_d;
      sat1_q <= pix_i.saturation; int1_q <= pix_i.intensity;
    end
    if (en2) begin
      sec2_q <= sec1_q; sat2_q <= sat1_q; int2_q <= int1_q;
      rat2_q <= ratio_rom[off1_q]; mn2_q <= mn2_d;
    end
    if (en3) begin
      sec3_q <= sec2_q; int3_q <= int2_q;
      sr3_q <= sr3_d; pm3_q <= pm3_d; ym3_q <= mn2_q;
    end
    if (en4) begin
      sec4_q <= sec3_q; int4_q <= int3_q; t4_q <= t4_d; mnr4_q <= mnr4_d;
    end
    if (en5) begin
      sec5_q <= sec4_q; int5_q <= int4_q; mnr5_q <= mnr4_q; num5_q <= num5_d;
    end
    if (en6) begin
      sec6_q <= sec5_q; int6_q <= int5_q; mnr6_q <= mnr5_q;
      y6_q <= y6_d; p6_q <= p6_d;
    end
    if (en7) begin
      sec7_q <= sec6_q; int7_q <= int6_q; mnr7_q <= mnr6_q; maj7_q <= maj7_d;
    end
    if (en8) begin
      red_q <= red_d; green_q <= green_d; blue_q <= blue_d;
    end
  end

  assign rgb_o.valid = vo_q;
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

`ifndef ASSERT_OFF
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v1_q)
    else $error("accepted word did not reach stage 1");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (off1_q < OFFSET_W'(TABLE_DEPTH)) && (sec1_q != 2'd3))
    else $error("hue offset or sector out of range");

  a_major_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> ry < (Y_W+1)'(510))
    else $error("major reciprocal estimate off by more than one");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && !rgb_o.ready && v7_q |=> v7_q && $stable(maj7_q))
    else $error("stage 7 lost a word under stall");
`endif

endmodule
